[rtl/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the segment LCD persistence block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  // Default geometry
  localparam int unsigned DEF_LINES   = 8;
  localparam int unsigned DEF_COMMONS = 2;
  localparam int unsigned DEF_SEGS    = 4;

  // Field widths
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LINE_W    = 3;
  localparam int unsigned SEG_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 1'd1;

  // Configuration reset values
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] RAMP_STEP_RST = 16'h1000;

  // Request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [LINE_W-1:0] line_index;
    logic [BYTE_W-1:0] data_byte;
    logic              common_index;
    logic [SEG_W-1:0]  segment_index;
  } req_t;

  typedef struct packed {
    logic               frame_done;
    logic [LEVEL_W-1:0] level;
    logic               seg_on;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic do_read;
    logic do_write;
    logic sweep_step;
    logic res_write;
    logic res_read;
    logic res_frame;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic frame_end;
    logic sweep_last;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

endpackage

`default_nettype wire

[rtl/lsp_ctrl.sv]
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer for requests: writes, memory reads and level sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ctrl import lsp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy_o
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode the next state and the datapath commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (status_i.is_read) begin
            cmd_o.do_read = 1'b1;
            state_d       = ST_READ;
          end else begin
            cmd_o.do_write = 1'b1;
            if (status_i.frame_end) begin
              state_d = ST_SWEEP;
            end else begin
              cmd_o.res_write = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd_o.res_read = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.res_frame = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[rtl/lsp_datapath.sv]
// ----------------------------------------------------------------------------
// lsp_datapath
// Segment byte registers, change mask, level memory with ramp/clamp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_datapath import lsp_pkg::*; #(
  parameter int unsigned LINES   = DEF_LINES,
  parameter int unsigned COMMONS = DEF_COMMONS,
  parameter int unsigned SEGS    = DEF_SEGS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire req_t                 req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LEVEL_W-1:0]   cfg_wdata_i,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o,
  output logic                      res_valid_o,
  output res_t                      res_o
);

  localparam int unsigned DEPTH = COMMONS * LINES * SEGS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;

  logic [LEVEL_W-1:0] max_level_q, ramp_step_q;
  logic [BYTE_W-1:0]  stored_q [LINES];
  logic [BYTE_W-1:0]  shown_q  [LINES];
  logic [BYTE_W-1:0]  mask_q, mask_d;

  logic [LW-1:0]      line_sel;
  logic               line_ok, wr_last;

  logic               h_q;
  logic [LW-1:0]      o_q;
  logic [SEG_W-1:0]   s_q;
  logic [AW-1:0]      addr_q;
  logic               pend_q;
  logic [AW-1:0]      wb_addr_q;
  logic               wb_on_q;

  logic [AW-1:0]      rd_req_addr, mem_addr;
  logic               rd_ok, rd_on;
  logic               rd_ok_q, rd_on_q;

  logic [LEVEL_W-1:0] mem_q [DEPTH];
  logic [LEVEL_W-1:0] rdata_q;
  logic               levels_ok_q;
  logic               ent_ok_q;
  logic [LEVEL_W-1:0] cur_level, wb_level;
  logic [LEVEL_W:0]   up_sum;

  logic               res_valid_q;
  res_t               res_q, res_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_RST;
      ramp_step_q <= RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LEVEL: max_level_q <= cfg_wdata_i;
        CFG_RAMP_STEP: ramp_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Decode the request line
  assign line_sel = LW'(req_i.line_index);
  assign line_ok  = int'(req_i.line_index) < LINES;
  assign wr_last  = line_ok && (int'(req_i.line_index) == LINES - 1);

  // Collect changed bits; line 0 opens a new pass
  assign mask_d = ((req_i.line_index == '0) ? '0 : mask_q)
                | (stored_q[line_sel] ^ req_i.data_byte);

  assign status_o.is_read    = (req_i.mode == MODE_READ);
  assign status_o.frame_end  = (req_i.mode == MODE_WRITE) && wr_last;
  assign status_o.sweep_last = (addr_q == AW'(DEPTH - 1));

  // Store segment bytes; latch the display bytes on a quiet frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int i = 0; i < LINES; i++) begin
        stored_q[i] <= '0;
        shown_q[i]  <= '0;
      end
    end else if (cmd_i.do_write && line_ok) begin
      stored_q[line_sel] <= req_i.data_byte;
      mask_q             <= mask_d;
      if (wr_last && (mask_d == '0)) begin
        for (int i = 0; i < LINES; i++) begin
          shown_q[i] <= (LW'(i) == line_sel) ? req_i.data_byte : stored_q[i];
        end
      end
    end
  end

  // Advance the sweep over all levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= 1'b0;
      o_q    <= '0;
      s_q    <= '0;
      addr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.sweep_step;
      if (cmd_i.do_write && wr_last) begin
        h_q    <= 1'b0;
        o_q    <= '0;
        s_q    <= '0;
        addr_q <= '0;
      end else if (cmd_i.sweep_step) begin
        addr_q <= addr_q + AW'(1);
        if (s_q == SEG_W'(SEGS - 1)) begin
          s_q <= '0;
          if (o_q == LW'(LINES - 1)) begin
            o_q <= '0;
            h_q <= ~h_q;
          end else begin
            o_q <= o_q + LW'(1);
          end
        end else begin
          s_q <= s_q + SEG_W'(1);
        end
      end
    end
  end

  // Carry the sweep address and display bit to the write-back stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      wb_addr_q <= addr_q;
      wb_on_q   <= shown_q[o_q][{h_q, s_q}];
    end
  end

  // Form the read request address and display bit
  assign rd_req_addr = AW'((int'(req_i.common_index) * LINES + int'(req_i.line_index)) * SEGS
                           + int'(req_i.segment_index));
  assign rd_ok       = line_ok && (int'(req_i.common_index) < COMMONS)
                    && (int'(req_i.segment_index) < SEGS);
  assign rd_on       = rd_ok && shown_q[line_sel][{req_i.common_index, req_i.segment_index}];
  assign mem_addr    = cmd_i.do_read ? rd_req_addr : addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_read) begin
      rd_ok_q <= rd_ok;
      rd_on_q <= rd_on;
    end
  end

  // Level memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem_q[wb_addr_q] <= wb_level;
    end
    rdata_q  <= mem_q[mem_addr];
    ent_ok_q <= levels_ok_q;
  end

  // Mark the levels written once the first sweep has finished; until then
  // every level reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_ok_q <= 1'b0;
    end else if (pend_q && (wb_addr_q == AW'(DEPTH - 1))) begin
      levels_ok_q <= 1'b1;
    end
  end

  assign cur_level = ent_ok_q ? rdata_q : '0;

  // Ramp one level and clamp to 0..max_level
  assign up_sum = {1'b0, cur_level} + {1'b0, ramp_step_q};
  always_comb begin
    if (wb_on_q) begin
      wb_level = (up_sum > {1'b0, max_level_q}) ? max_level_q : up_sum[LEVEL_W-1:0];
    end else if (cur_level < ramp_step_q) begin
      wb_level = '0;
    end else if ((cur_level - ramp_step_q) > max_level_q) begin
      wb_level = max_level_q;
    end else begin
      wb_level = cur_level - ramp_step_q;
    end
  end

  // Build the result
  always_comb begin
    res_d = '0;
    if (cmd_i.res_frame) begin
      res_d.frame_done = 1'b1;
    end else if (cmd_i.res_read) begin
      res_d.level  = rd_ok_q ? cur_level : '0;
      res_d.seg_on = rd_on_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_write || cmd_i.res_read || cmd_i.res_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/lcd_segment_persistence.sv]
// ----------------------------------------------------------------------------
// lcd_segment_persistence
// Segment LCD with persistence: stored bytes, display bytes, ramped levels.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; every request
// gives exactly one result, shown for one cycle under res_valid_o. A write
// that is not the last line of a frame leaves busy_o low and its result
// comes on the next cycle. A read holds busy_o high while the controller is
// in ST_READ; its result passes through the registered read of the level
// memory and then the result register. A write to the last line ends a
// frame: busy_o stays high through the sweep, which walks the level memory
// one entry a cycle, and through the drain state, and the frame result
// follows. Levels need no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_segment_persistence import lsp_pkg::*; #(
  parameter int unsigned LINES   = DEF_LINES,
  parameter int unsigned COMMONS = DEF_COMMONS,
  parameter int unsigned SEGS    = DEF_SEGS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire req_t                 req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LEVEL_W-1:0]   cfg_wdata_i,
  output logic                      res_valid_o,
  output res_t                      res_o
);

  cmd_t    cmd;
  status_t status;

  lsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lsp_datapath #(
    .LINES   (LINES),
    .COMMONS (COMMONS),
    .SEGS    (SEGS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // A read result follows the registered level memory read and the result register
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.mode == MODE_READ) |-> ##2 res_valid_o)
    else $error("read result missing");

  // A write inside a frame answers next cycle without a frame flag
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.mode == MODE_WRITE)
    && (int'(req_i.line_index) != LINES - 1)
    |=> res_valid_o && !res_o.frame_done)
    else $error("write result wrong");

  // The frame result only comes once the sweep has finished
  a_frame_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_done |-> !busy_o && (res_o.level == '0) && !res_o.seg_on)
    else $error("frame result during sweep");

  // Sweep steps only while a request is in progress
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_step |-> busy_o)
    else $error("sweep step while idle");
`endif

endmodule

`default_nettype wire

[sim/lsp_checker.sv]
// ----------------------------------------------------------------------------
// lsp_checker
// Watches the request, result and register ports of the segment LCD
// persistence block, predicts each result from its own copy of the stored
// bytes, display bytes, change mask and segment levels, and compares every
// result in order against the prediction.
// ----------------------------------------------------------------------------
module lsp_checker import lsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  req_t                 req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_wdata_i,
  input  logic                 res_valid_i,
  input  res_t                 res_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LINES   = DEF_LINES;
  localparam int NUM_COMMONS = DEF_COMMONS;
  localparam int NUM_SEGS    = DEF_SEGS;
  localparam int NUM_LEVELS  = NUM_COMMONS * NUM_LINES * NUM_SEGS;
  localparam int REPORT_MAX  = 10;

  // Shadow copy of the block's registers and memories
  logic [LEVEL_W-1:0] clamp_level;
  logic [LEVEL_W-1:0] step_size;
  logic [BYTE_W-1:0]  latch_bytes [NUM_LINES];
  logic [BYTE_W-1:0]  panel_bytes [NUM_LINES];
  logic [BYTE_W-1:0]  diff_bits;
  logic [LEVEL_W-1:0] seg_level [NUM_LEVELS];

  res_t segment_results_due[$];
  int   mismatch_count;

  // Latch the frame if it was steady, then ramp every segment toward its bit
  task automatic ramp_all_segments();
    int v;
    int slot;
    if (diff_bits == '0) begin
      for (int o = 0; o < NUM_LINES; o++) panel_bytes[o] = latch_bytes[o];
    end
    for (int h = 0; h < NUM_COMMONS; h++) begin
      for (int o = 0; o < NUM_LINES; o++) begin
        for (int s = 0; s < NUM_SEGS; s++) begin
          slot = (h * NUM_LINES + o) * NUM_SEGS + s;
          v = int'(seg_level[slot]);
          if (panel_bytes[o][h * 4 + s]) v = v + int'(step_size);
          else v = v - int'(step_size);
          if (v < 0) v = 0;
          if (v > int'(clamp_level)) v = int'(clamp_level);
          seg_level[slot] = v[LEVEL_W-1:0];
        end
      end
    end
  endtask

  // Apply one request to the shadow state and work out its result
  task automatic predict_segment_result(input req_t r, output res_t res);
    int line;
    int h;
    int s;
    res = '0;
    line = int'(r.line_index);
    h = int'(r.common_index);
    s = int'(r.segment_index);
    if (r.mode == MODE_WRITE) begin
      if (line < NUM_LINES) begin
        if (line == 0) diff_bits = '0;
        diff_bits = diff_bits | (latch_bytes[line] ^ r.data_byte);
        latch_bytes[line] = r.data_byte;
        if (line == NUM_LINES - 1) begin
          ramp_all_segments();
          res.frame_done = 1'b1;
        end
      end
    end else if (line < NUM_LINES && h < NUM_COMMONS && s < NUM_SEGS) begin
      res.level  = seg_level[(h * NUM_LINES + line) * NUM_SEGS + s];
      res.seg_on = panel_bytes[line][h * 4 + s];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t pred;
    if (!rst_ni) begin
      clamp_level = MAX_LEVEL_RST;
      step_size   = RAMP_STEP_RST;
      for (int o = 0; o < NUM_LINES; o++) begin
        latch_bytes[o] = '0;
        panel_bytes[o] = '0;
      end
      diff_bits = '0;
      for (int i = 0; i < NUM_LEVELS; i++) seg_level[i] = '0;
      segment_results_due.delete();
      mismatch_count = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare the result against the oldest prediction
      if (res_valid_i) begin
        if (segment_results_due.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("%t lsp_checker: result with no request waiting: fd=%0b lvl=%04h on=%0b",
                     $realtime, res_i.frame_done, res_i.level, res_i.seg_on);
          mismatch_count++;
        end else begin
          want = segment_results_due.pop_front();
          if (want.frame_done !== res_i.frame_done || want.level !== res_i.level ||
              want.seg_on !== res_i.seg_on) begin
            if (mismatch_count < REPORT_MAX)
              $display("%t lsp_checker: expected fd=%0b lvl=%04h on=%0b, got fd=%0b lvl=%04h on=%0b",
                       $realtime, want.frame_done, want.level, want.seg_on,
                       res_i.frame_done, res_i.level, res_i.seg_on);
            mismatch_count++;
          end
        end
      end

      // Track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_LEVEL) clamp_level = cfg_wdata_i;
        else if (cfg_idx_i == CFG_RAMP_STEP) step_size = cfg_wdata_i;
      end

      // Predict each accepted request
      if (start_i && !busy_i) begin
        predict_segment_result(req_i, pred);
        segment_results_due.push_back(pred);
      end

      fail_count_o <= mismatch_count;
      pending_o    <= segment_results_due.size();
    end
  end

endmodule

[sim/lcd_segment_persistence_tb.sv]
// ----------------------------------------------------------------------------
// lcd_segment_persistence_tb
// Drives the segment LCD persistence block with a directed opening and then
// random frames, reads and stray writes under several register settings and
// sender idle rates; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lcd_segment_persistence_tb import lsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_LINES   = DEF_LINES;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  req_t                 req_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LEVEL_W-1:0]   cfg_wdata_i;
  logic                 res_valid_o;
  res_t                 res_o;

  int fail_count;
  int pending_count;
  int cycle_count;
  int idle_pct;
  int requests_sent;

  logic [BYTE_W-1:0] frame_bytes [NUM_LINES];

  lcd_segment_persistence DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  lsp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Idle at random, then hold the request until it is taken
  task automatic issue_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic write_line(input int line, input logic [BYTE_W-1:0] data);
    req_t r;
    r = req_t'($urandom);
    r.mode       = MODE_WRITE;
    r.line_index = line[LINE_W-1:0];
    r.data_byte  = data;
    issue_request(r);
  endtask

  task automatic read_segment(input int line, input int h, input int s);
    req_t r;
    r = req_t'($urandom);
    r.mode          = MODE_READ;
    r.line_index    = line[LINE_W-1:0];
    r.common_index  = h[0];
    r.segment_index = s[SEG_W-1:0];
    issue_request(r);
  endtask

  task automatic read_any();
    read_segment($urandom_range(NUM_LINES - 1), $urandom_range(1), $urandom_range(3));
  endtask

  // Wait until every result is in and the block has gone quiet
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly whole frames, often repeated so they latch, plus reads and strays
  task automatic run_random(input int quota);
    int goal;
    int pick;
    int o;
    int b;
    goal = requests_sent + quota;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($urandom_range(1)) begin
          for (o = 0; o < NUM_LINES; o++)
            frame_bytes[o] = ($urandom_range(3) == 0) ?
                             ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
        end else if ($urandom_range(3) == 0) begin
          // Break the steady frame by one bit
          o = $urandom_range(NUM_LINES - 1);
          b = $urandom_range(7);
          frame_bytes[o][b] = ~frame_bytes[o][b];
        end
        for (o = 0; o < NUM_LINES; o++) begin
          write_line(o, frame_bytes[o]);
          if ($urandom_range(99) < 25) read_any();
        end
      end else if (pick < 85) begin
        read_any();
      end else begin
        write_line($urandom_range(NUM_LINES - 1), 8'($urandom));
      end
    end
  endtask

  task automatic configure(input logic [LEVEL_W-1:0] max_lvl, input logic [LEVEL_W-1:0] step);
    drain();
    write_register(CFG_MAX_LEVEL, max_lvl);
    write_register(CFG_RAMP_STEP, step);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_i         = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    cycle_count   = 0;
    idle_pct      = 0;
    requests_sent = 0;
    for (int o = 0; o < NUM_LINES; o++) frame_bytes[o] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: read at reset, a changing frame, the same frame again to latch
    read_segment(0, 0, 0);
    for (int pass = 0; pass < 2; pass++) begin
      for (int o = 0; o < NUM_LINES; o++)
        write_line(o, (o == NUM_LINES - 1) ? 8'h5A : ((o % 2 == 0) ? 8'hFF : 8'h00));
    end
    read_segment(NUM_LINES - 1, 1, 3);
    read_segment(NUM_LINES - 1, 0, 1);
    read_segment(0, 0, 0);
    read_segment(1, 1, 2);
    // Stray write in mid frame, then a frame end without latching
    write_line(3, 8'hA5);
    write_line(NUM_LINES - 1, 8'h00);
    read_segment(3, 1, 3);

    // Lower the clamp under raised levels, then sweep the settings
    configure(16'h0800, 16'h0000);
    write_line(NUM_LINES - 1, 8'h00);
    read_segment(0, 0, 0);

    configure(16'hFFFF, 16'hFFFF);
    run_random(130);
    idle_pct = 77;
    configure(16'h1234, 16'h0001);
    run_random(130);
    idle_pct = 17;
    configure(16'h0000, 16'h8000);
    run_random(130);
    idle_pct = 0;
    configure(16'hC000, 16'h0800);
    run_random(130);
    idle_pct = 77;
    configure(16'hFFFF, 16'h0000);
    run_random(60);
    idle_pct = 0;
    configure(MAX_LEVEL_RST, RAMP_STEP_RST);
    run_random(70);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lsp_pkg.sv
rtl/lsp_ctrl.sv
rtl/lsp_datapath.sv
rtl/lcd_segment_persistence.sv
sim/lsp_checker.sv
sim/lcd_segment_persistence_tb.sv
